// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the serializer top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, skipped while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clk edge.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/spws_pkg.sv =====
// Types and constants shared by the sequin serializer modules.
package spws_pkg;

	// Default depth of the pattern bit store
	localparam int MaxSequinsDefault = 256;

	// Word actions
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_ACK   = 2'd2;

	// Frame timing
	localparam logic [1:0] START_LAST_TICK = 2'd3;
	localparam logic [1:0] BIT_LAST_TICK   = 2'd3;
	localparam logic [1:0] LOW_LEN_ONE     = 2'd2;
	localparam logic [1:0] LOW_LEN_ZERO    = 2'd1;
	localparam logic [1:0] TRAIL_LAST_TICK = 2'd1;

	// Frame phase
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_START = 2'd1,
		PH_BITS  = 2'd2,
		PH_TRAIL = 2'd3
	} phase_t;

	// One input word
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] bit_index;
		logic       bit_value;
		logic       start_request;
	} item_t;

	// One result word
	typedef struct packed {
		logic done_res;
		logic busy_res;
		logic data_line;
	} result_t;

endpackage

// ===== rtl/core/spws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spws_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = spws_pkg::MaxSequinsDefault
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds data when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/spws_engine.sv =====
// Frame sequencer: phase, tick and sequin counters, done flag and line level.
module spws_engine #(
	parameter int MAX_SEQUINS = spws_pkg::MaxSequinsDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           rd_en,
	input  spws_pkg::item_t                item,
	input  logic [7:0]                     last_index,
	input  logic                           rd_bit,
	output logic [$clog2(MAX_SEQUINS)-1:0] raddr,
	output logic                           wr_en,
	output logic [$clog2(MAX_SEQUINS)-1:0] wr_addr,
	output logic                           wr_bit,
	output spws_pkg::result_t              res_d
);

	localparam int AW = $clog2(MAX_SEQUINS);
	localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_SEQUINS - 1);

	spws_pkg::phase_t phase_q, phase_d;
	logic [1:0]       tick_q, tick_d;
	logic [8:0]       pos_q, pos_d;
	logic [AW-1:0]    addr_q, addr_d;
	logic             done_q, done_d;
	logic             line_q, line_d;
	logic             fwd_q;
	logic             fwd_bit_q;
	logic             cur_bit;
	logic [1:0]       low_len;
	logic [8:0]       seq_count;

	// Bit of the current sequin, with a write from the word just before it
	assign cur_bit   = fwd_q ? fwd_bit_q : rd_bit;
	assign low_len   = cur_bit ? spws_pkg::LOW_LEN_ONE : spws_pkg::LOW_LEN_ZERO;
	assign seq_count = {1'b0, last_index} + 9'd1;

	assign wr_addr = AW'(item.bit_index);
	assign wr_bit  = item.bit_value;

	// Next state for the word in flight
	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		pos_d   = pos_q;
		addr_d  = addr_q;
		done_d  = done_q;
		line_d  = line_q;
		wr_en   = 1'b0;
		if (en) begin
			unique case (item.action)
				spws_pkg::ACT_TICK: begin
					if (phase_d == spws_pkg::PH_IDLE && item.start_request && !done_d) begin
						phase_d = spws_pkg::PH_START;
						tick_d  = 2'd0;
					end
					unique case (phase_d)
						spws_pkg::PH_START: begin
							line_d = 1'b1;
							if (tick_d < spws_pkg::START_LAST_TICK) begin
								tick_d = tick_d + 2'd1;
							end else begin
								tick_d  = 2'd0;
								pos_d   = 9'd0;
								addr_d  = '0;
								phase_d = spws_pkg::PH_BITS;
								line_d  = 1'b0;
							end
						end
						spws_pkg::PH_BITS: begin
							if (pos_d < seq_count) begin
								tick_d = tick_d + 2'd1;
								if (tick_d < low_len) begin
									line_d = 1'b0;
								end else if (tick_d < spws_pkg::BIT_LAST_TICK) begin
									line_d = 1'b1;
								end else begin
									line_d = 1'b0;
									tick_d = 2'd0;
									pos_d  = pos_d + 9'd1;
									addr_d = (addr_d == ADDR_LAST) ? '0 : addr_d + AW'(1);
								end
							end else begin
								line_d  = 1'b0;
								phase_d = spws_pkg::PH_TRAIL;
								tick_d  = 2'd0;
							end
						end
						spws_pkg::PH_TRAIL: begin
							line_d = 1'b0;
							if (tick_d < spws_pkg::TRAIL_LAST_TICK) begin
								tick_d = tick_d + 2'd1;
							end else begin
								tick_d  = 2'd0;
								phase_d = spws_pkg::PH_IDLE;
								done_d  = 1'b1;
							end
						end
						default: begin
							line_d = 1'b0;
						end
					endcase
				end
				spws_pkg::ACT_WRITE: begin
					wr_en = ({24'd0, item.bit_index} < 32'(MAX_SEQUINS));
				end
				spws_pkg::ACT_ACK: begin
					done_d = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Read the bit of the position the next word will see
	assign raddr = addr_d;

	assign res_d.data_line = line_d;
	assign res_d.busy_res  = (phase_d != spws_pkg::PH_IDLE);
	assign res_d.done_res  = done_d;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= spws_pkg::PH_IDLE;
			tick_q  <= 2'd0;
			pos_q   <= 9'd0;
			addr_q  <= '0;
			done_q  <= 1'b0;
			line_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			pos_q   <= pos_d;
			addr_q  <= addr_d;
			done_q  <= done_d;
			line_q  <= line_d;
		end
	end

	// Forward a write that lands on the address read at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q     <= 1'b0;
			fwd_bit_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q     <= wr_en && (wr_addr == addr_d);
			fwd_bit_q <= item.bit_value;
		end
	end

endmodule

// ===== rtl/core/sequin_pulse_width_serializer.sv =====
// Top level of the sequin data-line serializer: stream ports, word and result registers.
// Takes one word per clock while the output is not stalled and returns one result word
// per input word.
// Each word is held in an input stage while the pattern bit store is read for it (the
// store has a registered read port, addressed when the word is accepted). Then one step
// of the frame sequencer runs, and the new line level, busy and done flags land in the
// output register.
// Tick words advance the frame; pattern bits are written with write words and the
// done flag is cleared with an acknowledge word. The user must write last_sequin_index
// over the cfg port only while no word is in flight; the block does not enforce it.
// The bit store is not cleared at reset: every bit a frame sends must be written first.
`include "assert_macros.svh"

module sequin_pulse_width_serializer #(
	parameter int MAX_SEQUINS = spws_pkg::MaxSequinsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] bit_index, [8] bit_value, [9] start_request
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] data_line, [1] busy_res, [2] done_res
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // [7:0] last_sequin_index
);

	localparam int AW = $clog2(MAX_SEQUINS);

	spws_pkg::item_t   item_s1;
	logic              valid_s1;
	spws_pkg::result_t res_d;
	spws_pkg::result_t res_q;
	logic [7:0]        last_index_q;
	logic              advance;
	logic              accept;
	logic              rd_bit;
	logic [AW-1:0]     raddr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic              wr_bit;

	// Handshake
	assign advance   = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Register the last sequin index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			last_index_q <= cfg_data;
		end
	end

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action        <= s_tuser;
			item_s1.bit_index     <= s_tdata[7:0];
			item_s1.bit_value     <= s_tdata[8];
			item_s1.start_request <= s_tdata[9];
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_tdata = {5'd0, res_q.done_res, res_q.busy_res, res_q.data_line};

	spws_ram #(
		.WIDTH (1),
		.DEPTH (MAX_SEQUINS)
	) u_bits (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_bit),
		.re    (accept),
		.raddr (raddr),
		.rdata (rd_bit)
	);

	spws_engine #(
		.MAX_SEQUINS (MAX_SEQUINS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.rd_en      (accept),
		.item       (item_s1),
		.last_index (last_index_q),
		.rd_bit     (rd_bit),
		.raddr      (raddr),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_bit     (wr_bit),
		.res_d      (res_d)
	);

	// A frame starts only with done clear, and done is set as it ends
	`ASSERT_NEVER(a_busy_done_excl, m_tvalid && m_tdata[1] && m_tdata[2], "busy and done both set")
	// A word in the input stage is never dropped while the output stalls
	`ASSERT_CLK(a_s1_hold, valid_s1 && !advance |=> valid_s1, "input stage word lost")
	// Nothing is written to the bit store except by a word moving on
	`ASSERT_CLK(a_write_on_advance, wr_en |-> advance, "bit store written without a word")

endmodule

// ===== dv/spws_line_checker.sv =====
// Checker for the sequin serializer: mirrors the frame sequencer and compares each result word.
`timescale 1ns / 100ps

module spws_line_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] bit_index, [8] bit_value, [9] start_request
	input  logic [1:0]  s_tuser,   // [1:0] action
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [0] data_line, [1] busy_res, [2] done_res
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,  // [7:0] last_sequin_index
	output int          mismatches,
	output int          pending
);

	import spws_pkg::*;

	// Mirrored serializer state and register
	phase_t     ph;
	logic [1:0] tick_cnt;
	logic [8:0] seq_pos;
	logic       pattern [MaxSequinsDefault];
	logic       done;
	logic       line;
	logic [7:0] last_idx;

	// Line states still owed by the block, oldest first
	result_t    line_states_due [$];
	int         results_seen;

	// Print one mismatch line and count it
	task automatic report_mismatch(input string msg);
		$display("mismatch at result word %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	// Advance the frame sequencer by one tick
	task automatic sequencer_tick(input logic start);
		logic [1:0] low_len;
		if (ph == PH_IDLE && start && !done) begin
			ph = PH_START;
			tick_cnt = '0;
		end
		case (ph)
			PH_START: begin
				line = 1'b1;
				if (tick_cnt < START_LAST_TICK) begin
					tick_cnt = tick_cnt + 2'd1;
				end else begin
					tick_cnt = '0;
					seq_pos = '0;
					ph = PH_BITS;
					line = 1'b0;
				end
			end
			PH_BITS: begin
				// seq_pos <= last index is the same test as seq_pos < last index + 1
				if (seq_pos <= {1'b0, last_idx}) begin
					low_len = pattern[seq_pos % MaxSequinsDefault] ? LOW_LEN_ONE : LOW_LEN_ZERO;
					tick_cnt = tick_cnt + 2'd1;
					if (tick_cnt < low_len) begin
						line = 1'b0;
					end else if (tick_cnt < BIT_LAST_TICK) begin
						line = 1'b1;
					end else begin
						line = 1'b0;
						tick_cnt = '0;
						seq_pos = seq_pos + 9'd1;
					end
				end else begin
					line = 1'b0;
					ph = PH_TRAIL;
					tick_cnt = '0;
				end
			end
			PH_TRAIL: begin
				line = 1'b0;
				if (tick_cnt < TRAIL_LAST_TICK) begin
					tick_cnt = tick_cnt + 2'd1;
				end else begin
					tick_cnt = '0;
					ph = PH_IDLE;
					done = 1'b1;
				end
			end
			default: line = 1'b0;
		endcase
	endtask

	// Apply one accepted word and queue the line state it leaves behind
	task automatic apply_word(input item_t w);
		result_t r;
		case (w.action)
			ACT_TICK: sequencer_tick(w.start_request);
			ACT_WRITE: begin
				if (w.bit_index < MaxSequinsDefault)
					pattern[w.bit_index] = w.bit_value;
			end
			ACT_ACK: done = 1'b0;
			default: ;
		endcase
		r.data_line = line;
		r.busy_res = (ph != PH_IDLE);
		r.done_res = done;
		line_states_due.push_back(r);
	endtask

	// Watch the three channels; inputs are applied before outputs are matched
	always @(posedge clk or negedge arst_n) begin : watch
		item_t   w;
		result_t got;
		result_t want;
		if (!arst_n) begin
			ph = PH_IDLE;
			tick_cnt = '0;
			seq_pos = '0;
			done = 1'b0;
			line = 1'b0;
			last_idx = '0;
			line_states_due.delete();
			results_seen = 0;
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				last_idx = cfg_data;
			if (s_tvalid && s_tready) begin
				w.action = s_tuser;
				w.bit_index = s_tdata[7:0];
				w.bit_value = s_tdata[8];
				w.start_request = s_tdata[9];
				apply_word(w);
			end
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[2:0]);
				if (line_states_due.size() == 0) begin
					report_mismatch($sformatf("result word %b with none expected", m_tdata));
				end else begin
					want = line_states_due.pop_front();
					if (got.data_line !== want.data_line)
						report_mismatch($sformatf("data_line %b, expected %b",
							got.data_line, want.data_line));
					if (got.busy_res !== want.busy_res)
						report_mismatch($sformatf("busy_res %b, expected %b",
							got.busy_res, want.busy_res));
					if (got.done_res !== want.done_res)
						report_mismatch($sformatf("done_res %b, expected %b",
							got.done_res, want.done_res));
				end
				results_seen++;
			end
			pending = line_states_due.size();
		end
	end

endmodule

// ===== dv/sequin_pulse_width_serializer_test.sv =====
// Top of the serializer testbench: clock, reset, word stimulus, stalls and the verdict.
`timescale 1ns / 100ps

module sequin_pulse_width_serializer_test;

	import spws_pkg::*;

	// Action code the block must ignore
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int CycleLimit = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [7:0] bit_index, [8] bit_value, [9] start_request
	logic [1:0]  s_tuser = '0;   // [1:0] action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [0] data_line, [1] busy_res, [2] done_res
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;  // [7:0] last_sequin_index

	int mismatches;
	int pending;
	int tx_idle_pct = 31;
	int rx_idle_pct = 50;
	int words_sent = 0;
	int cycle_count = 0;

	// Generate the 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sequin_pulse_width_serializer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	spws_line_checker line_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Stall the result channel at random
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("run stopped after %0d cycles without finishing", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic item_t make_word(input logic [1:0] act, input logic [7:0] idx,
			input logic val, input logic start);
		item_t w;
		w.action = act;
		w.bit_index = idx;
		w.bit_value = val;
		w.start_request = start;
		return w;
	endfunction

	// Mostly ticks, with writes, acknowledges and the odd unused code mixed in
	function automatic item_t random_word();
		item_t w;
		int pick;
		pick = $urandom_range(99);
		if (pick < 72)
			w.action = ACT_TICK;
		else if (pick < 86)
			w.action = ACT_WRITE;
		else if (pick < 95)
			w.action = ACT_ACK;
		else
			w.action = ACT_UNUSED;
		w.bit_index = 8'($urandom);
		w.bit_value = 1'($urandom);
		w.start_request = ($urandom_range(99) < 60);
		return w;
	endfunction

	// Present one word after a random gap and hold it until accepted
	task automatic send_word(input item_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, w.start_request, w.bit_value, w.bit_index};
		s_tuser <= w.action;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every result word is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic write_last_index(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random phase: drain, set stalls and last index, then send
	task automatic run_random(input logic [7:0] last_idx, input int tx_pct, input int rx_pct,
			input int count);
		wait_drained();
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		write_last_index(last_idx);
		repeat (count) send_word(random_word());
	endtask

	initial begin : stimulus
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: idle actions, ignored code, then one three-sequin frame
		write_last_index(8'd2);
		send_word(make_word(ACT_TICK, 8'd0, 1'b0, 1'b0));
		send_word(make_word(ACT_ACK, 8'd0, 1'b0, 1'b0));
		send_word(make_word(ACT_UNUSED, 8'hFF, 1'b1, 1'b1));
		send_word(make_word(ACT_WRITE, 8'd0, 1'b1, 1'b0));
		send_word(make_word(ACT_WRITE, 8'd1, 1'b0, 1'b0));
		send_word(make_word(ACT_WRITE, 8'd2, 1'b1, 1'b0));
		send_word(make_word(ACT_TICK, 8'd0, 1'b0, 1'b1));
		repeat (3) send_word(make_word(ACT_TICK, 8'd0, 1'b0, 1'b0));
		// acknowledge mid-frame, and rewrite a bit not yet sent
		send_word(make_word(ACT_ACK, 8'd0, 1'b0, 1'b0));
		send_word(make_word(ACT_WRITE, 8'd1, 1'b1, 1'b0));
		// start requests during the frame must be ignored
		repeat (12) send_word(make_word(ACT_TICK, 8'd0, 1'b0, 1'b1));
		// done still set: no new frame until acknowledged
		send_word(make_word(ACT_TICK, 8'd0, 1'b0, 1'b1));
		send_word(make_word(ACT_ACK, 8'd0, 1'b0, 1'b0));

		// Fill the whole store so no frame can read an unwritten bit
		for (int i = 0; i < MaxSequinsDefault; i++)
			send_word(make_word(ACT_WRITE, 8'(i), 1'($urandom), 1'b0));

		// Random phases: longest frame, shortest frame, mid length
		run_random(8'd255, 31, 50, 300);
		run_random(8'd0, 50, 31, 200);
		run_random(8'd31, 0, 0, 170);

		wait_drained();
		repeat (4) @(negedge clk);
		$display("%0d words sent: directed frame, full store fill, random traffic", words_sent);
		$display("last sequin index stepped through 2, 255, 0 and 31 under three stall mixes");
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sequin_pulse_width_serializer.f =====
+incdir+rtl/core
rtl/core/spws_pkg.sv
rtl/core/spws_ram.sv
rtl/core/spws_engine.sv
rtl/core/sequin_pulse_width_serializer.sv
dv/spws_line_checker.sv
dv/sequin_pulse_width_serializer_test.sv
